// ===== hdl/gnci_pkg.sv =====
// Shared types, constants and helper functions for the grid neighbor index core.
// Used by every module under hdl; no dependencies of its own.
package gnci_pkg;

  localparam int IDX_W      = 24;  // packed cell index width
  localparam int NUM_W      = 7;   // neighbor number width
  localparam int DIMS_W     = 3;   // dims_in_use register width
  localparam int LOG_W      = 5;   // log_size register width
  localparam int MAX_DIMS   = 4;
  localparam int INDEX_BITS = 24;  // widest grid the index may describe
  localparam int SHF_W      = 7;   // field offsets and sums of log sizes (up to 4*31)
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOG1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOG3 = 3'd4;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd3;
  localparam logic [LOG_W-1:0]  LOG_RESET  = 5'd4;

  // Base-3 digit codes and the step each one selects
  typedef logic [1:0] trit_t;
  typedef trit_t [MAX_DIMS-1:0] trits_t;
  localparam trit_t TRIT_ZERO = 2'd0;
  localparam trit_t TRIT_UP   = 2'd1;
  localparam trit_t TRIT_DOWN = 2'd2;

  typedef logic signed [1:0] ofs_t;
  localparam ofs_t OFS_ZERO = 2'sb00;
  localparam ofs_t OFS_UP   = 2'sb01;
  localparam ofs_t OFS_DOWN = 2'sb11;

  // Grid geometry derived from the configuration registers
  typedef struct packed {
    logic [MAX_DIMS-1:0]            used;
    logic [MAX_DIMS-1:0][LOG_W-1:0] log_size;
    logic [MAX_DIMS-1:0][SHF_W-1:0] shift;
    logic [SHF_W-1:0]               total;
    logic [NUM_W-1:0]               num_lim;
    logic                           geo_ok;
  } geo_t;

  // Decode stage result
  typedef struct packed {
    logic [IDX_W-1:0] center;
    trits_t           trits;
    logic             pre_ok;
  } s1_t;

  // Step stage result
  typedef struct packed {
    logic [MAX_DIMS-1:0][IDX_W-1:0] moved;
    ofs_t [MAX_DIMS-1:0]            ofs;
    logic                           ok;
  } s2_t;

  // Result register contents
  typedef struct packed {
    ofs_t [MAX_DIMS-1:0] ofs;
    logic [IDX_W-1:0]    neighbor_index;
    logic                valid_res;
  } res_t;

  // Place weights of the base-3 digits, and twice those weights
  localparam logic [NUM_W:0] TRIT_W1 [MAX_DIMS] = '{8'd1, 8'd3, 8'd9, 8'd27};
  localparam logic [NUM_W:0] TRIT_W2 [MAX_DIMS] = '{8'd2, 8'd6, 8'd18, 8'd54};

  // Split a value below 81 into base-3 digits by compare and subtract,
  // most significant digit first. Larger values give don't-care digits.
  function automatic trits_t to_trits(input logic [NUM_W:0] v);
    logic [NUM_W:0] r;
    trits_t         t;
    r = v;
    for (int i = MAX_DIMS - 1; i >= 0; i--) begin
      if (r >= TRIT_W2[i]) begin
        t[i] = TRIT_DOWN;
        r    = r - TRIT_W2[i];
      end else if (r >= TRIT_W1[i]) begin
        t[i] = TRIT_UP;
        r    = r - TRIT_W1[i];
      end else begin
        t[i] = TRIT_ZERO;
      end
    end
    return t;
  endfunction

  // Neighbor count 3^dims - 1 for each legal dimension count
  function automatic logic [NUM_W-1:0] num_limit(input logic [DIMS_W-1:0] dims);
    logic [NUM_W-1:0] lim;
    unique case (dims)
      3'd1:    lim = 7'd2;
      3'd2:    lim = 7'd8;
      3'd3:    lim = 7'd26;
      3'd4:    lim = 7'd80;
      default: lim = 7'd0;
    endcase
    return lim;
  endfunction

endpackage

// ===== hdl/gnci_decode.sv =====
// First pipeline stage: base-3 digit split and whole-item range checks.
// Depends on gnci_pkg.
module gnci_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gnci_pkg::IDX_W-1:0]  center,
  input  logic [gnci_pkg::NUM_W-1:0]  num,
  input  gnci_pkg::geo_t              geo,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gnci_pkg::s1_t               out_data
);

  logic          valid_r;
  gnci_pkg::s1_t data_r;
  gnci_pkg::s1_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt.center = center;
    data_nxt.trits  = gnci_pkg::to_trits({1'b0, num} + 8'd1);
    data_nxt.pre_ok = geo.geo_ok && (num < geo.num_lim) &&
                      ((center >> geo.total) == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/gnci_step.sv =====
// Second pipeline stage: per-dimension coordinate extract, step and edge check.
// Depends on gnci_pkg.
module gnci_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gnci_pkg::s1_t  in_data,
  input  gnci_pkg::geo_t geo,
  output logic           out_valid,
  input  logic           out_ready,
  output gnci_pkg::s2_t  out_data
);

  logic                                                  valid_r;
  gnci_pkg::s2_t                                         data_r;
  gnci_pkg::s2_t                                         data_nxt;
  logic [gnci_pkg::MAX_DIMS-1:0][gnci_pkg::IDX_W-1:0]    mask;
  logic [gnci_pkg::MAX_DIMS-1:0][gnci_pkg::IDX_W-1:0]    coord;
  logic [gnci_pkg::MAX_DIMS-1:0]                         hit;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Dimensions are independent: each one checks its own field, no carry.
  always_comb begin
    for (int i = 0; i < gnci_pkg::MAX_DIMS; i++) begin
      mask[i]  = ~({gnci_pkg::IDX_W{1'b1}} << geo.log_size[i]);
      coord[i] = (in_data.center >> geo.shift[i]) & mask[i];
      hit[i]   = 1'b0;
      data_nxt.moved[i] = coord[i];
      data_nxt.ofs[i]   = gnci_pkg::OFS_ZERO;
      if (geo.used[i]) begin
        case (in_data.trits[i])
          gnci_pkg::TRIT_UP: begin
            hit[i]            = (coord[i] == mask[i]);
            data_nxt.moved[i] = (coord[i] + gnci_pkg::IDX_W'(1)) & mask[i];
            data_nxt.ofs[i]   = gnci_pkg::OFS_UP;
          end
          gnci_pkg::TRIT_DOWN: begin
            hit[i]            = (coord[i] == '0);
            data_nxt.moved[i] = (coord[i] - gnci_pkg::IDX_W'(1)) & mask[i];
            data_nxt.ofs[i]   = gnci_pkg::OFS_DOWN;
          end
          default: begin
            data_nxt.moved[i] = coord[i];
          end
        endcase
      end else begin
        data_nxt.moved[i] = '0;
      end
    end
    data_nxt.ok = in_data.pre_ok && !(|hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/gnci_merge.sv =====
// Last pipeline stage and result register: repack the moved fields, zero on failure.
// Depends on gnci_pkg.
module gnci_merge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gnci_pkg::s2_t  in_data,
  input  gnci_pkg::geo_t geo,
  output logic           out_valid,
  input  logic           out_ready,
  output gnci_pkg::res_t out_data
);

  logic                          valid_r;
  gnci_pkg::res_t                data_r;
  gnci_pkg::res_t                data_nxt;
  logic [gnci_pkg::IDX_W-1:0]    packed_idx;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    packed_idx = '0;
    for (int i = 0; i < gnci_pkg::MAX_DIMS; i++) begin
      packed_idx = packed_idx | (in_data.moved[i] << geo.shift[i]);
    end
    data_nxt.valid_res = in_data.ok;
    data_nxt.neighbor_index = in_data.ok ? packed_idx : '0;
    for (int i = 0; i < gnci_pkg::MAX_DIMS; i++) begin
      data_nxt.ofs[i] = in_data.ok ? in_data.ofs[i] : gnci_pkg::OFS_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/grid_neighbor_cell_index_core.sv =====
// Grid neighbor cell index core: Moore-neighborhood lookup on a packed power-of-two grid.
// Depends on gnci_pkg, gnci_decode, gnci_step and gnci_merge.
//
// Each input transfer carries the packed index of a center cell and a neighbor
// number; each one produces exactly one output transfer with the neighbor's
// packed index, a valid flag (on out_tuser) and the step along each dimension.
// The grid has dims_in_use dimensions (1 to 4), dimension d taking log_size_d
// bits of the index with dimension 0 lowest. The neighbor number plus one is
// read in base 3, dimension 0 least significant; digit 1 steps +1, digit 2
// steps -1. A bad dimension count, a grid wider than 24 bits, a neighbor
// number at or above 3^dims-1, a center outside the grid or a step that leaves
// its own field all give valid 0 with a zero index and zero offsets; steps
// never carry from one field into the next. The datapath is a three-stage
// pipeline (digit split and range checks, per-field step and edge check,
// repack into the result register): one transfer is taken every clock unless
// the full pipeline is stalled, and each result passes through the decode,
// step and merge registers before it appears on out_tvalid.
// A stall on out_tready holds every stage in place and pushes back
// on in_tready only once the pipeline is full; empty stages keep filling while
// a result waits. Write configuration only while the pipeline is empty; the
// geometry is decoded straight from the registers and used by all stages.
module grid_neighbor_cell_index_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [23:0] cell_index, [30:24] neighbor_number, [31] zero fill
  input  logic [gnci_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [23:0] neighbor_index, [25:24] offset_0, [27:26] offset_1,
  // [29:28] offset_2, [31:30] offset_3
  output logic [gnci_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] valid_res
  output logic                              out_tuser,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [gnci_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [gnci_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [gnci_pkg::DIMS_W-1:0]                        dims_r;
  logic [gnci_pkg::MAX_DIMS-1:0][gnci_pkg::LOG_W-1:0] log_size_r;
  gnci_pkg::geo_t                                     geo;
  logic [gnci_pkg::SHF_W-1:0]                         shift_acc;

  logic           s1_valid;
  logic           s1_ready;
  gnci_pkg::s1_t  s1_data;
  logic           s2_valid;
  logic           s2_ready;
  gnci_pkg::s2_t  s2_data;
  gnci_pkg::res_t res;

  // Configuration registers; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r     <= gnci_pkg::DIMS_RESET;
      log_size_r <= {gnci_pkg::MAX_DIMS{gnci_pkg::LOG_RESET}};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        gnci_pkg::REG_DIMS: dims_r        <= cfg_wdata[gnci_pkg::DIMS_W-1:0];
        gnci_pkg::REG_LOG0: log_size_r[0] <= cfg_wdata;
        gnci_pkg::REG_LOG1: log_size_r[1] <= cfg_wdata;
        gnci_pkg::REG_LOG2: log_size_r[2] <= cfg_wdata;
        gnci_pkg::REG_LOG3: log_size_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Geometry: which dimensions are live, where each field starts, total
  // width and the neighbor count. Only changes with configuration.
  always_comb begin
    shift_acc = '0;
    for (int i = 0; i < gnci_pkg::MAX_DIMS; i++) begin
      geo.used[i]     = (gnci_pkg::DIMS_W'(i) < dims_r);
      geo.log_size[i] = log_size_r[i];
      geo.shift[i]    = shift_acc;
      if (geo.used[i]) begin
        shift_acc = shift_acc + gnci_pkg::SHF_W'(log_size_r[i]);
      end
    end
    geo.total   = shift_acc;
    geo.num_lim = gnci_pkg::num_limit(dims_r);
    geo.geo_ok  = (dims_r >= gnci_pkg::DIMS_W'(1)) &&
                  (dims_r <= gnci_pkg::DIMS_W'(gnci_pkg::MAX_DIMS)) &&
                  (shift_acc <= gnci_pkg::SHF_W'(gnci_pkg::INDEX_BITS));
  end

  // Stage 1: digit split and whole-item checks
  gnci_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .center    (in_tdata[gnci_pkg::IDX_W-1:0]),
    .num       (in_tdata[gnci_pkg::IDX_W +: gnci_pkg::NUM_W]),
    .geo       (geo),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // Stage 2: per-field step and edge check
  gnci_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .geo       (geo),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // Stage 3: repack into the result register
  gnci_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .geo       (geo),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {res.ofs[3], res.ofs[2], res.ofs[1], res.ofs[0], res.neighbor_index};
  assign out_tuser = res.valid_res;

endmodule

// ===== hdl/gnci_checker.sv =====
// Port-level checks on the grid neighbor index core, bound to the top level.
// Depends on gnci_pkg and grid_neighbor_cell_index_core.
module gnci_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [gnci_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // No result in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

  // A refused neighbor carries a zero index and zero offsets
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid result with nonzero payload");

  // An accepted neighbor always moves along at least one dimension
  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[31:24] != 8'd0)
    else $error("valid result without any step");

  // Offsets never take the unused code
  a_ofs_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:24] != 2'b10 && out_tdata[27:26] != 2'b10 &&
                   out_tdata[29:28] != 2'b10 && out_tdata[31:30] != 2'b10)
    else $error("offset holds unused code");

endmodule

bind grid_neighbor_cell_index_core gnci_checker u_gnci_checker (.*);

// ===== verif/tb_grid_neighbor_cell_index_core.sv =====
// Self-checking testbench for grid_neighbor_cell_index_core: directed corner queries,
// then randomized neighbor queries under many grid geometries with random stalls.
// Depends on gnci_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_grid_neighbor_cell_index_core;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PIPE_DEPTH  = 3;    // decode, step and merge stages between an input transfer and its result

  typedef struct {
    logic [gnci_pkg::IDX_W-1:0] center;
    logic [gnci_pkg::NUM_W-1:0] num;
  } query_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [gnci_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [gnci_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             cfg_we    = 1'b0;
  logic [gnci_pkg::CFG_IDX_W-1:0]   cfg_idx   = '0;
  logic [gnci_pkg::CFG_W-1:0]       cfg_wdata = '0;

  grid_neighbor_cell_index_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow copy of the grid geometry registers, kept in step with every write
  logic [gnci_pkg::DIMS_W-1:0] dims_cfg = gnci_pkg::DIMS_RESET;
  logic [gnci_pkg::LOG_W-1:0]  log_cfg [gnci_pkg::MAX_DIMS] =
    '{gnci_pkg::LOG_RESET, gnci_pkg::LOG_RESET, gnci_pkg::LOG_RESET, gnci_pkg::LOG_RESET};

  query_t         query_q[$];            // queries waiting for the driver
  gnci_pkg::res_t neighbor_expect_q[$];  // predicted neighbors, oldest first

  int fail_count     = 0;
  int queries_queued = 0;
  int queries_sent   = 0;
  int results_seen   = 0;
  int inside_count   = 0;
  int settings_run   = 0;
  int cycle_count    = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  int recv_next;
  bit send_steady    = 1'b0;
  bit recv_steady    = 1'b0;
  query_t         drv_item;
  gnci_pkg::res_t want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Neighbor prediction from the shadow geometry: range checks first, then
  // one base-3 digit per dimension, each field stepped and checked on its own.
  function automatic gnci_pkg::res_t predict_neighbor(
      input logic [gnci_pkg::IDX_W-1:0] center,
      input logic [gnci_pkg::NUM_W-1:0] num);
    gnci_pkg::res_t             r;
    bit                         ok;
    int                         total, lim, digits, shift, d;
    gnci_pkg::trit_t            trit;
    logic [gnci_pkg::IDX_W-1:0] span_mask, coord, moved;
    r     = '0;
    total = 0;
    lim   = 1;
    shift = 0;
    ok    = (dims_cfg >= 1) && (dims_cfg <= gnci_pkg::MAX_DIMS);
    if (ok) begin
      for (d = 0; d < dims_cfg; d++) begin
        total += log_cfg[d];
        lim   *= 3;
      end
      if (total > gnci_pkg::INDEX_BITS)
        ok = 1'b0;
      else if (num >= lim - 1)
        ok = 1'b0;
      else if (center >= (longint'(1) << total))
        ok = 1'b0;
    end
    if (ok) begin
      digits = num + 1;
      for (d = 0; d < dims_cfg && ok; d++) begin
        span_mask = (24'd1 << log_cfg[d]) - 24'd1;
        coord     = (center >> shift) & span_mask;
        trit      = gnci_pkg::trit_t'(digits % 3);
        digits    = digits / 3;
        moved     = coord;
        if (trit == gnci_pkg::TRIT_UP) begin
          // stepping past the top of the field is out of the grid, no carry
          if (coord == span_mask) ok = 1'b0;
          moved    = coord + 24'd1;
          r.ofs[d] = gnci_pkg::OFS_UP;
        end else if (trit == gnci_pkg::TRIT_DOWN) begin
          if (coord == '0) ok = 1'b0;
          moved    = coord - 24'd1;
          r.ofs[d] = gnci_pkg::OFS_DOWN;
        end
        r.neighbor_index |= (moved & span_mask) << shift;
        shift += log_cfg[d];
      end
    end
    if (ok)
      r.valid_res = 1'b1;
    else
      r = '0;
    return r;
  endfunction

  // Idle cycles before the next transfer on one side; zero in steady stretches
  function automatic int draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic check_field(input string what, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
      fail_count++;
    end
  endtask

  task automatic queue_query(input logic [gnci_pkg::IDX_W-1:0] center,
                             input logic [gnci_pkg::NUM_W-1:0] num);
    query_t q;
    q.center = center;
    q.num    = num;
    query_q  = {query_q, q};
    queries_queued++;
  endtask

  // Drive one register write and mirror it into the shadow geometry
  task automatic write_reg(input logic [gnci_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gnci_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      gnci_pkg::REG_DIMS: dims_cfg   = value[gnci_pkg::DIMS_W-1:0];
      gnci_pkg::REG_LOG0: log_cfg[0] = value;
      gnci_pkg::REG_LOG1: log_cfg[1] = value;
      gnci_pkg::REG_LOG2: log_cfg[2] = value;
      gnci_pkg::REG_LOG3: log_cfg[3] = value;
      default: ;
    endcase
  endtask

  // Hold until every queued query is answered, then let the pipeline settle
  task automatic wait_idle();
    while (results_seen != queries_queued)
      @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Program one grid geometry and run random queries against it. Most queries
  // are well formed: a center built field by field (edges favored) and a legal
  // neighbor number. The rest are raw noise over the center and number fields.
  task automatic run_phase(input logic [gnci_pkg::DIMS_W-1:0] dims,
                           input logic [gnci_pkg::LOG_W-1:0] l0,
                           input logic [gnci_pkg::LOG_W-1:0] l1,
                           input logic [gnci_pkg::LOG_W-1:0] l2,
                           input logic [gnci_pkg::LOG_W-1:0] l3,
                           input int count);
    logic [gnci_pkg::LOG_W-1:0] logs [gnci_pkg::MAX_DIMS];
    logic [gnci_pkg::IDX_W-1:0] center, coord, mask;
    logic [gnci_pkg::NUM_W-1:0] num;
    int                         total, lim, shift, d, k;
    bit                         legal;
    logs = '{l0, l1, l2, l3};
    // junk in the upper data bits of the dimension write must be dropped
    write_reg(gnci_pkg::REG_DIMS, {2'($urandom_range(0, 3)), dims});
    write_reg(gnci_pkg::REG_LOG0, l0);
    write_reg(gnci_pkg::REG_LOG1, l1);
    write_reg(gnci_pkg::REG_LOG2, l2);
    write_reg(gnci_pkg::REG_LOG3, l3);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
    total = 0;
    lim   = 1;
    for (d = 0; d < dims && d < gnci_pkg::MAX_DIMS; d++) begin
      total += logs[d];
      lim   *= 3;
    end
    legal = (dims >= 1) && (dims <= gnci_pkg::MAX_DIMS) && (total <= gnci_pkg::INDEX_BITS);
    for (k = 0; k < count; k++) begin
      if (legal && $urandom_range(0, 9) != 0) begin
        center = '0;
        shift  = 0;
        for (d = 0; d < dims; d++) begin
          mask = (24'd1 << logs[d]) - 24'd1;
          case ($urandom_range(0, 3))
            0: coord = '0;
            1: coord = mask;
            default: coord = gnci_pkg::IDX_W'($urandom()) & mask;
          endcase
          center |= coord << shift;
          shift  += logs[d];
        end
        num = gnci_pkg::NUM_W'($urandom_range(0, lim - 2));
      end else begin
        center = gnci_pkg::IDX_W'($urandom());
        num    = gnci_pkg::NUM_W'($urandom());
      end
      queue_query(center, num);
    end
    wait_idle();
  endtask

  // Driver: present queued queries, predict each one at its transfer, and
  // insert a random gap before the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        neighbor_expect_q = {neighbor_expect_q,
                             predict_neighbor(in_tdata[gnci_pkg::IDX_W-1:0],
                                              in_tdata[gnci_pkg::IDX_W +: gnci_pkg::NUM_W])};
        queries_sent++;
        // re-draw the pacing mode now and then so bursts alternate with gaps
        if (queries_sent % 50 == 0) send_steady = ($urandom_range(0, 3) == 0);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (query_q.size() != 0) begin
          drv_item  = query_q.pop_front();
          in_tdata  <= {1'b0, drv_item.num, drv_item.center};
          in_tvalid <= 1'b1;
          send_gap  <= draw_wait(send_steady);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction, then
  // stall the result side for a random number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= 0;
    end else begin
      recv_next = recv_gap;
      if (out_tvalid && out_tready) begin
        if (neighbor_expect_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual index %0d valid %0d",
                   $time, out_tdata[gnci_pkg::IDX_W-1:0], out_tuser);
          fail_count++;
        end else begin
          want = neighbor_expect_q.pop_front();
          if (want.valid_res) inside_count++;
          check_field("valid_res", int'(want.valid_res), int'(out_tuser));
          check_field("neighbor_index", int'(want.neighbor_index),
                      int'(out_tdata[gnci_pkg::IDX_W-1:0]));
          for (int d = 0; d < gnci_pkg::MAX_DIMS; d++)
            check_field($sformatf("offset_%0d", d), int'(want.ofs[d]),
                        int'($signed(out_tdata[gnci_pkg::IDX_W + 2*d +: 2])));
        end
        results_seen++;
        if (results_seen % 50 == 0) recv_steady = ($urandom_range(0, 3) == 0);
        recv_next = draw_wait(recv_steady);
      end
      if (recv_next > 0) begin
        out_tready <= 1'b0;
        recv_gap   <= recv_next - 1;
      end else begin
        out_tready <= 1'b1;
        recv_gap   <= 0;
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, neighbor_expect_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Corner queries on the reset geometry: three dimensions of 16 cells
    queue_query(24'h000000, 7'd0);    // origin, +1 along dimension 0
    queue_query(24'h000000, 7'd1);    // origin, -1 falls off the low edge
    queue_query(24'h000000, 7'd12);   // origin, +1 on every axis
    queue_query(24'h000000, 7'd25);   // last neighbor, -1 on every axis
    queue_query(24'h000000, 7'd26);   // neighbor number one past the last
    queue_query(24'h000000, 7'd127);  // largest neighbor number
    queue_query(24'h000FFF, 7'd0);    // far corner, +1 off the top edge
    queue_query(24'h000FFF, 7'd1);
    queue_query(24'h000FFF, 7'd25);
    queue_query(24'h000FFF, 7'd12);
    queue_query(24'h001000, 7'd0);    // center just outside the grid
    queue_query(24'hFFFFFF, 7'd79);   // every index bit set
    queue_query(24'h000888, 7'd12);
    queue_query(24'h000888, 7'd25);
    queue_query(24'h000888, 7'd8);
    queue_query(24'h000888, 7'd2);
    queue_query(24'h0000F0, 7'd4);    // field at top next to field at bottom
    queue_query(24'h000F0F, 7'd17);
    queue_query(24'h000777, 7'd80);
    queue_query(24'h00051A, 7'd13);
    wait_idle();

    // Geometries: widest single field, size-one fields, exactly 24 bits wide,
    // size-two fields, too wide, illegal dimension counts, and mixed sizes
    run_phase(3'd1, 5'd24, 5'd0,  5'd0,  5'd0,  150);
    run_phase(3'd1, 5'd0,  5'd5,  5'd5,  5'd5,  40);
    run_phase(3'd2, 5'd12, 5'd12, 5'd31, 5'd31, 200);
    run_phase(3'd2, 5'd1,  5'd1,  5'd0,  5'd0,  150);
    run_phase(3'd4, 5'd6,  5'd6,  5'd6,  5'd6,  250);
    run_phase(3'd4, 5'd1,  5'd2,  5'd3,  5'd4,  200);
    run_phase(3'd4, 5'd0,  5'd24, 5'd0,  5'd0,  100);
    run_phase(3'd3, 5'd8,  5'd8,  5'd9,  5'd0,  40);
    run_phase(3'd4, 5'd31, 5'd31, 5'd31, 5'd31, 40);
    run_phase(3'd0, 5'd4,  5'd4,  5'd4,  5'd4,  40);
    run_phase(3'd7, 5'd2,  5'd2,  5'd2,  5'd2,  40);
    run_phase(3'd5, 5'd1,  5'd1,  5'd1,  5'd1,  40);
    run_phase(3'd3, 5'd2,  5'd3,  5'd5,  5'd7,  250);
    run_phase(3'd4, 5'd3,  5'd3,  5'd3,  5'd3,  250);
    run_phase(3'd2, 5'd10, 5'd5,  5'd0,  5'd0,  150);
    run_phase(3'd3, 5'd4,  5'd4,  5'd4,  5'd4,  60);

    if (neighbor_expect_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected 0 outstanding",
               $time, neighbor_expect_q.size());
      fail_count++;
    end

    $display("Checked %0d neighbor queries over %0d register settings plus reset geometry,",
             results_seen, settings_run);
    $display("%0d neighbors inside the grid, the rest rejected; %0d mismatches.",
             inside_count, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
